[rtl/udp_port_nat_table_core_macros.svh]
// Assertion helpers for the table core RTL.
`ifndef UDP_PORT_NAT_TABLE_CORE_MACROS_SVH
`define UDP_PORT_NAT_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPNT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("upnt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UPNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("upnt assertion failed");

`endif

[rtl/upnt_pkg.sv]
`default_nettype none
package upnt_pkg;

	localparam int unsigned KEY_W      = 16;
	localparam int unsigned TABLE_DEPTH = 1 << KEY_W;
	localparam int unsigned COUNT_W    = KEY_W + 1;
	localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

	localparam logic [15:0] RESET_RELAY_PORT   = 16'd0;
	localparam logic [15:0] RESET_GC_INTERVAL  = 16'd60;
	localparam logic [15:0] RESET_IDLE_TIMEOUT = 16'd120;

	typedef enum logic [1:0] {
		CMD_OUTBOUND = 2'd0,
		CMD_INBOUND  = 2'd1,
		CMD_LOOKUP   = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_RELAY_PORT   = 2'd0,
		REG_GC_INTERVAL  = 2'd1,
		REG_IDLE_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	// One flow entry as held in the payload memory.
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
		logic [31:0] process_id;
		logic [31:0] interface_index;
		logic [31:0] last_seen;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[rtl/upnt_ram.sv]
`default_nettype none
module upnt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/udp_port_nat_table_core.sv]
`default_nettype none
// Channel        | Signals                                        | Transaction
// command in     | start, busy, command, src_ip .. interface_index | start && !busy
// result out     | done, handled, out_*, flow_count               | done, one cycle
// configuration  | cfg_we, cfg_index, cfg_wdata                   | cfg_we
//
// A packet, lookup or tick without a sweep issues its memory read when accepted, then
// does the read-modify-write and the result register load; the result strobes in the cycle after.
// A tick that sweeps reads one table entry per cycle, then passes a drain state; it reads
// through the single read port of the table memories.
// After reset the valid memory is cleared, one entry per cycle;
// busy stays high meanwhile. Configuration writes are taken at any time.
// Results cannot be stalled; each is shown for exactly one cycle with done.
`include "udp_port_nat_table_core_macros.svh"
module udp_port_nat_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] src_ip,
	input  wire logic [31:0] dst_ip,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [31:0] process_id,
	input  wire logic [31:0] interface_index,
	output logic             done,
	output logic             handled,
	output logic [31:0]      out_src_ip,
	output logic [31:0]      out_dst_ip,
	output logic [15:0]      out_src_port,
	output logic [15:0]      out_dst_port,
	output logic [31:0]      out_process_id,
	output logic [31:0]      out_interface_index,
	output logic [16:0]      flow_count,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam int unsigned KW = upnt_pkg::KEY_W;

	// Configuration registers.
	logic [15:0] relay_port_q, gc_interval_q, idle_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_port_q   <= upnt_pkg::RESET_RELAY_PORT;
			gc_interval_q  <= upnt_pkg::RESET_GC_INTERVAL;
			idle_timeout_q <= upnt_pkg::RESET_IDLE_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				upnt_pkg::REG_RELAY_PORT:   relay_port_q   <= cfg_wdata;
				upnt_pkg::REG_GC_INTERVAL:  gc_interval_q  <= cfg_wdata;
				upnt_pkg::REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	upnt_pkg::state_t st_q, st_d;

	logic              accept;
	logic [KW-1:0]     swp_q;        // clear and sweep address
	logic              swv_s2;       // a sweep read is returning this cycle
	logic [KW-1:0]     swa_s2;       // address of that read
	logic [31:0]       time_q, last_swp_q;
	logic [upnt_pkg::COUNT_W-1:0] cnt_q;

	// Inputs of the item in flight.
	upnt_pkg::cmd_t    cmd_s1;
	logic [31:0]       sip_s1, dip_s1, pid_s1, ifx_s1;
	logic [15:0]       sport_s1, dport_s1;
	logic [KW-1:0]     key_s1;

	// Memory ports.
	logic              p_we, v_we, v_wdata, v_rdata;
	logic [KW-1:0]     v_waddr, raddr;
	upnt_pkg::entry_t  p_wdata, p_rdata;

	// Result values computed in the access or drain state.
	logic              r_handled;
	logic [31:0]       r_sip, r_dip, r_pid, r_ifx;
	logic [15:0]       r_sport, r_dport;
	logic              cnt_inc, cnt_dec;

	logic [31:0]       time_nx, age;
	logic              tick_sweeps, ob_ok, ib_hit;

	assign accept      = start && !busy;
	assign time_nx     = time_q + 32'd1;
	assign tick_sweeps = (time_nx - last_swp_q) >= {16'd0, gc_interval_q};
	assign age         = time_q - p_rdata.last_seen;
	assign ob_ok       = (sip_s1 != upnt_pkg::LOOPBACK_ADDR) &&
	                     (dip_s1 != upnt_pkg::LOOPBACK_ADDR);
	assign ib_hit      = (sport_s1 == relay_port_q) &&
	                     (sip_s1 == upnt_pkg::LOOPBACK_ADDR) && v_rdata;

	// Sweep reads use the sweep address; inbound packets are keyed by destination port, everything else by source port.
	assign raddr = (st_q == upnt_pkg::ST_SWEEP) ? swp_q :
	               ((upnt_pkg::cmd_t'(command) == upnt_pkg::CMD_INBOUND) ?
	                dst_port[KW-1:0] : src_port[KW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= upnt_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state, memory writes and result values.
	always_comb begin
		st_d      = st_q;
		p_we      = 1'b0;
		p_wdata   = p_rdata;
		v_we      = 1'b0;
		v_waddr   = key_s1;
		v_wdata   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		r_handled = 1'b0;
		r_sip     = sip_s1;
		r_dip     = dip_s1;
		r_sport   = sport_s1;
		r_dport   = dport_s1;
		r_pid     = 32'd0;
		r_ifx     = 32'd0;
		unique case (st_q)
			upnt_pkg::ST_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = swp_q;
				if (&swp_q) begin
					st_d = upnt_pkg::ST_IDLE;
				end
			end
			upnt_pkg::ST_IDLE: begin
				if (accept) begin
					if (upnt_pkg::cmd_t'(command) == upnt_pkg::CMD_TICK && tick_sweeps) begin
						st_d = upnt_pkg::ST_SWEEP;
					end else begin
						st_d = upnt_pkg::ST_ACCESS;
					end
				end
			end
			upnt_pkg::ST_ACCESS: begin
				st_d = upnt_pkg::ST_IDLE;
				unique case (cmd_s1)
					upnt_pkg::CMD_OUTBOUND: begin
						if (ob_ok) begin
							v_we    = 1'b1;
							v_wdata = 1'b1;
							cnt_inc = !v_rdata;
							p_we    = 1'b1;
							p_wdata = '{src_ip: sip_s1, dst_ip: dip_s1, dst_port: dport_s1,
							            process_id: pid_s1, interface_index: ifx_s1,
							            last_seen: time_q};
							r_handled = 1'b1;
							r_sip     = upnt_pkg::LOOPBACK_ADDR;
							r_dip     = upnt_pkg::LOOPBACK_ADDR;
							r_dport   = relay_port_q;
						end
					end
					upnt_pkg::CMD_INBOUND: begin
						if (ib_hit) begin
							p_we              = 1'b1;
							p_wdata.last_seen = time_q;
							r_handled = 1'b1;
							r_sip     = p_rdata.dst_ip;
							r_dip     = p_rdata.src_ip;
							r_sport   = p_rdata.dst_port;
							r_ifx     = p_rdata.interface_index;
						end
					end
					upnt_pkg::CMD_LOOKUP: begin
						if (v_rdata) begin
							r_handled = 1'b1;
							r_sip     = p_rdata.src_ip;
							r_dip     = p_rdata.dst_ip;
							r_dport   = p_rdata.dst_port;
							r_pid     = p_rdata.process_id;
						end else begin
							r_sip   = 32'd0;
							r_dip   = 32'd0;
							r_dport = 16'd0;
						end
					end
					upnt_pkg::CMD_TICK: begin
						r_sip   = 32'd0;
						r_dip   = 32'd0;
						r_sport = 16'd0;
						r_dport = 16'd0;
					end
					default: ;
				endcase
			end
			upnt_pkg::ST_SWEEP, upnt_pkg::ST_DRAIN: begin
				if (st_q == upnt_pkg::ST_DRAIN) begin
					st_d = upnt_pkg::ST_IDLE;
				end else if (&swp_q) begin
					st_d = upnt_pkg::ST_DRAIN;
				end
				// Retire the entry whose read returns now if it has gone idle.
				v_waddr = swa_s2;
				if (swv_s2 && v_rdata && (age > {16'd0, idle_timeout_q})) begin
					v_we    = 1'b1;
					cnt_dec = 1'b1;
				end
				r_sip   = 32'd0;
				r_dip   = 32'd0;
				r_sport = 16'd0;
				r_dport = 16'd0;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_q      <= '0;
			swv_s2     <= 1'b0;
			time_q     <= 32'd0;
			last_swp_q <= 32'd0;
			cnt_q      <= '0;
			done       <= 1'b0;
		end else begin
			swv_s2 <= (st_q == upnt_pkg::ST_SWEEP);
			if (st_q == upnt_pkg::ST_CLEAR || st_q == upnt_pkg::ST_SWEEP) begin
				swp_q <= swp_q + 1'b1;
			end
			if (accept && upnt_pkg::cmd_t'(command) == upnt_pkg::CMD_TICK) begin
				time_q <= time_nx;
				swp_q  <= '0;
				if (tick_sweeps) begin
					last_swp_q <= time_nx;
				end
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			done <= (st_q == upnt_pkg::ST_ACCESS) || (st_q == upnt_pkg::ST_DRAIN);
		end
	end

	// Item capture and result registers.
	always_ff @(posedge clk) begin
		swa_s2 <= swp_q;
		if (accept) begin
			cmd_s1   <= upnt_pkg::cmd_t'(command);
			sip_s1   <= src_ip;
			dip_s1   <= dst_ip;
			sport_s1 <= src_port;
			dport_s1 <= dst_port;
			pid_s1   <= process_id;
			ifx_s1   <= interface_index;
			key_s1   <= raddr;
		end
		if (st_q == upnt_pkg::ST_ACCESS || st_q == upnt_pkg::ST_DRAIN) begin
			handled             <= r_handled;
			out_src_ip          <= r_sip;
			out_dst_ip          <= r_dip;
			out_src_port        <= r_sport;
			out_dst_port        <= r_dport;
			out_process_id      <= r_pid;
			out_interface_index <= r_ifx;
		end
	end

	assign busy       = (st_q != upnt_pkg::ST_IDLE);
	assign flow_count = cnt_q;

	upnt_ram #(
		.WIDTH(upnt_pkg::ENTRY_W),
		.DEPTH(upnt_pkg::TABLE_DEPTH)
	) u_payload_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(key_s1),
		.wdata(p_wdata),
		.raddr(raddr),
		.rdata(p_rdata)
	);

	upnt_ram #(
		.WIDTH(1),
		.DEPTH(upnt_pkg::TABLE_DEPTH)
	) u_valid_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(raddr),
		.rdata(v_rdata)
	);

	`UPNT_ASSERT_NEXT(a_access_gives_result, clk, arst_n, st_q == upnt_pkg::ST_ACCESS, done)
	`UPNT_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, accept, busy)
	`UPNT_ASSERT_SAME(a_sweep_only_clears, clk, arst_n, v_we && st_q == upnt_pkg::ST_SWEEP, !v_wdata)
	`UPNT_ASSERT_SAME(a_count_bounded, clk, arst_n, 1'b1, cnt_q <= upnt_pkg::COUNT_W'(upnt_pkg::TABLE_DEPTH))

endmodule
`default_nettype wire
